>>> rtl/sti_pkg.sv
// ---------------------------------------------------------------------------
// sti_pkg: shared types and codes for the sorted trajectory interpolator
// Holds the table entry layout, the sequencer states and the status codes.
// ---------------------------------------------------------------------------
package sti_pkg;

    // One stored trajectory point, time stamp in the low bits
    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
        logic        [31:0] tstamp;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT,
        S_PLACE,
        S_Q_FIRST_RD,
        S_Q_FIRST,
        S_Q_RD_P,
        S_Q_RD_K,
        S_Q_LAT_K,
        S_AX_INIT,
        S_MUL,
        S_DIV,
        S_AX_DONE,
        S_FINISH
    } state_t;

    // Function select carried in s_tuser
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_CLAMP = 2'd1;
    localparam logic [1:0] STAT_PAST  = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    // Iteration counts of the shared multiply / divide unit
    localparam logic [6:0] MUL_STEPS = 7'd32;
    localparam logic [6:0] DIV_STEPS = 7'd65;

    // Bounding box reset values
    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

endpackage

>>> rtl/sorted_trajectory_interpolator.sv
// ---------------------------------------------------------------------------
// sorted_trajectory_interpolator: time-sorted point table with interpolation
// Insert: binary search, then one move per entry above the slot through the
//   single table port, then the new point is written. Query: binary search,
//   then a clamp to the first entry, a past-end status, or per axis a
//   shift-add multiply and a restoring divide.
// Throughput: one word at a time; the next word is taken once the result is
//   in the output register. Reset (aresetn low, synchronous) empties the
//   table, the span and the bounding box; no clearing pass is needed.
// ---------------------------------------------------------------------------
module sorted_trajectory_interpolator #(
    parameter int DEPTH = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] sample_time, [63:32] in_x, [95:64] in_y, [127:96] in_z
    input  logic [127:0] s_tdata,
    // [0] func
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] box_min_x,
    // [159:128] box_min_y, [191:160] box_min_z, [223:192] box_max_x,
    // [255:224] box_max_y, [287:256] box_max_z
    output logic [287:0] m_tdata,
    // [1:0] status, [2] in_span
    output logic [2:0]   m_tuser
);
    import sti_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    // Point table
    entry_t mem [DEPTH];
    entry_t rd_q;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CW-1:0] left_reg, left_next;
    logic [AW-1:0] idx_reg, idx_next, wa_reg, wa_next;
    logic          pend_reg, pend_next;
    logic          func_reg, func_next;
    entry_t        new_reg, new_next, ent_p_reg, ent_p_next, ent_k_reg, ent_k_next;
    logic [31:0]   num_reg, num_next, den_reg, den_next;
    logic [31:0]   rem_reg, rem_next;
    logic [64:0]   pr_reg, pr_next;
    logic [32:0]   mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [6:0]    step_reg, step_next;
    logic [1:0]    axis_reg, axis_next;
    logic [1:0]    stat_reg, stat_next;
    logic signed [31:0] res_reg [3];
    logic signed [31:0] res_next [3];
    logic signed [31:0] bmin_reg [3];
    logic signed [31:0] bmin_next [3];
    logic signed [31:0] bmax_reg [3];
    logic signed [31:0] bmax_next [3];
    logic [31:0]   early_reg, early_next, late_reg, late_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [287:0]  m_tdata_reg, m_tdata_next;
    logic [2:0]    m_tuser_reg, m_tuser_next;

    // Combinational helpers
    logic [CW-1:0]      mid_c;
    logic               go_right;
    logic signed [31:0] last_c, cur_c;
    logic signed [32:0] dir_c;
    logic [33:0]        msum_c;
    logic [32:0]        rsh_c;
    logic               qbit_c;
    logic signed [33:0] lerp_c;
    logic               span_c;

    // Table port: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    // Register update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            early_reg    <= '1;
            late_reg     <= '0;
            for (int i = 0; i < 3; i++) begin
                bmin_reg[i] <= POS_MAX;
                bmax_reg[i] <= POS_MIN;
            end
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            early_reg    <= early_next;
            late_reg     <= late_next;
            for (int i = 0; i < 3; i++) begin
                bmin_reg[i] <= bmin_next[i];
                bmax_reg[i] <= bmax_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        left_reg    <= left_next;
        idx_reg     <= idx_next;
        wa_reg      <= wa_next;
        func_reg    <= func_next;
        new_reg     <= new_next;
        ent_p_reg   <= ent_p_next;
        ent_k_reg   <= ent_k_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        pr_reg      <= pr_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        step_reg    <= step_next;
        axis_reg    <= axis_next;
        stat_reg    <= stat_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        for (int i = 0; i < 3; i++) begin
            res_reg[i] <= res_next[i];
        end
    end

    // Shared datapath pieces
    always_comb begin
        mid_c    = lo_reg + ((hi_reg - lo_reg) >> 1);
        go_right = (func_reg == FUNC_INSERT) ? (rd_q.tstamp <= new_reg.tstamp)
                                             : (rd_q.tstamp <  new_reg.tstamp);
        case (axis_reg)
            2'd0: begin
                last_c = ent_p_reg.x;
                cur_c  = ent_k_reg.x;
            end
            2'd1: begin
                last_c = ent_p_reg.y;
                cur_c  = ent_k_reg.y;
            end
            default: begin
                last_c = ent_p_reg.z;
                cur_c  = ent_k_reg.z;
            end
        endcase
        dir_c  = 33'(cur_c) - 33'(last_c);
        msum_c = {1'b0, pr_reg[64:32]} + (pr_reg[0] ? {1'b0, mag_reg} : 34'd0);
        rsh_c  = {rem_reg, pr_reg[64]};
        qbit_c = (rsh_c >= {1'b0, den_reg});
        lerp_c = neg_reg ? (34'(last_c) - $signed({1'b0, pr_reg[32:0]}))
                         : (34'(last_c) + $signed({1'b0, pr_reg[32:0]}));
        span_c = (cnt_reg != '0) && (new_reg.tstamp >= early_reg)
                 && (new_reg.tstamp <= late_reg);
    end

    // Sequencer: next state and datapath control
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        left_next     = left_reg;
        idx_next      = idx_reg;
        wa_next       = wa_reg;
        pend_next     = pend_reg;
        func_next     = func_reg;
        new_next      = new_reg;
        ent_p_next    = ent_p_reg;
        ent_k_next    = ent_k_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        pr_next       = pr_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        step_next     = step_reg;
        axis_next     = axis_reg;
        stat_next     = stat_reg;
        early_next    = early_reg;
        late_next     = late_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg;
        for (int i = 0; i < 3; i++) begin
            res_next[i]  = res_reg[i];
            bmin_next[i] = bmin_reg[i];
            bmax_next[i] = bmax_reg[i];
        end
        rd_addr  = mid_c[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = wa_reg;
        wr_data  = rd_q;
        s_tready = (state_reg == S_IDLE);

        // Drop the output word once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next         = s_tuser[0];
                    new_next.tstamp   = s_tdata[31:0];
                    new_next.x        = s_tdata[63:32];
                    new_next.y        = s_tdata[95:64];
                    new_next.z        = s_tdata[127:96];
                    lo_next           = '0;
                    hi_next           = cnt_reg;
                    stat_next         = STAT_OK;
                    for (int i = 0; i < 3; i++) begin
                        res_next[i] = '0;
                    end
                    if (s_tuser[0] == FUNC_INSERT && cnt_reg == CNT_FULL) begin
                        stat_next  = STAT_FULL;
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_SRCH_RD;
                    end
                end
            end
            // Binary search: issue the probe read
            S_SRCH_RD: begin
                if (lo_reg < hi_reg) begin
                    rd_addr    = mid_c[AW-1:0];
                    mid_next   = mid_c;
                    state_next = S_SRCH_CMP;
                end else if (func_reg == FUNC_INSERT) begin
                    left_next  = cnt_reg - lo_reg;
                    idx_next   = AW'(cnt_reg - 1'b1);
                    pend_next  = 1'b0;
                    state_next = S_SHIFT;
                end else if (lo_reg >= cnt_reg) begin
                    stat_next  = STAT_PAST;
                    state_next = S_FINISH;
                end else if (lo_reg == '0) begin
                    state_next = S_Q_FIRST_RD;
                end else begin
                    state_next = S_Q_RD_P;
                end
            end
            S_SRCH_CMP: begin
                if (go_right) begin
                    lo_next = mid_reg + 1'b1;
                end else begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH_RD;
            end
            // Move entries up one place, top first, one per cycle
            S_SHIFT: begin
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = wa_reg;
                    wr_data = rd_q;
                end
                if (left_reg != '0) begin
                    rd_addr   = idx_reg;
                    wa_next   = idx_reg + 1'b1;
                    idx_next  = idx_reg - 1'b1;
                    left_next = left_reg - 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = S_PLACE;
                    end
                end
            end
            // Write the new point and widen box and span
            S_PLACE: begin
                wr_en    = 1'b1;
                wr_addr  = lo_reg[AW-1:0];
                wr_data  = new_reg;
                cnt_next = cnt_reg + 1'b1;
                if (new_reg.x < bmin_reg[0]) bmin_next[0] = new_reg.x;
                if (new_reg.y < bmin_reg[1]) bmin_next[1] = new_reg.y;
                if (new_reg.z < bmin_reg[2]) bmin_next[2] = new_reg.z;
                if (new_reg.x > bmax_reg[0]) bmax_next[0] = new_reg.x;
                if (new_reg.y > bmax_reg[1]) bmax_next[1] = new_reg.y;
                if (new_reg.z > bmax_reg[2]) bmax_next[2] = new_reg.z;
                if (new_reg.tstamp < early_reg) early_next = new_reg.tstamp;
                if (new_reg.tstamp > late_reg)  late_next  = new_reg.tstamp;
                state_next = S_FINISH;
            end
            S_Q_FIRST_RD: begin
                rd_addr    = '0;
                state_next = S_Q_FIRST;
            end
            // Clamp to the first entry
            S_Q_FIRST: begin
                res_next[0] = rd_q.x;
                res_next[1] = rd_q.y;
                res_next[2] = rd_q.z;
                stat_next   = STAT_CLAMP;
                state_next  = S_FINISH;
            end
            S_Q_RD_P: begin
                rd_addr    = AW'(lo_reg - 1'b1);
                state_next = S_Q_RD_K;
            end
            S_Q_RD_K: begin
                rd_addr    = lo_reg[AW-1:0];
                ent_p_next = rd_q;
                state_next = S_Q_LAT_K;
            end
            S_Q_LAT_K: begin
                ent_k_next = rd_q;
                num_next   = new_reg.tstamp - ent_p_reg.tstamp;
                den_next   = rd_q.tstamp - ent_p_reg.tstamp;
                axis_next  = '0;
                state_next = S_AX_INIT;
            end
            // Load magnitude and direction of one axis
            S_AX_INIT: begin
                neg_next   = dir_c[32];
                mag_next   = dir_c[32] ? 33'(-dir_c) : 33'(dir_c);
                pr_next    = {33'd0, num_reg};
                step_next  = '0;
                state_next = S_MUL;
            end
            // Shift-add multiply: mag * num
            S_MUL: begin
                pr_next   = {msum_c, pr_reg[31:1]};
                step_next = step_reg + 1'b1;
                if (step_reg == MUL_STEPS - 1'b1) begin
                    step_next  = '0;
                    rem_next   = '0;
                    state_next = S_DIV;
                end
            end
            // Restoring divide: product / den
            S_DIV: begin
                rem_next  = qbit_c ? 32'(rsh_c - {1'b0, den_reg}) : rsh_c[31:0];
                pr_next   = {pr_reg[63:0], qbit_c};
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_STEPS - 1'b1) begin
                    state_next = S_AX_DONE;
                end
            end
            S_AX_DONE: begin
                res_next[axis_reg] = lerp_c[31:0];
                if (axis_reg == 2'd2) begin
                    state_next = S_FINISH;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_AX_INIT;
                end
            end
            // Hand the result word to the output register
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {bmax_reg[2], bmax_reg[1], bmax_reg[0],
                                     bmin_reg[2], bmin_reg[1], bmin_reg[0],
                                     res_reg[2], res_reg[1], res_reg[0]};
                    m_tuser_next  = {span_c, stat_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Table never overfills
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("entry count above depth");

    // A placed point grows the count by one
    a_place_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PLACE |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("count did not advance on insert");

    // Reject only when full
    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && stat_reg == STAT_FULL) |-> cnt_reg == CNT_FULL)
        else $error("insert rejected with room left");

    // Shifting never starts from a full table
    a_shift_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT |-> cnt_reg < CNT_FULL)
        else $error("shift with full table");

endmodule

>>> dv/sorted_trajectory_interpolator_tb.sv
// ---------------------------------------------------------------------------
// sorted_trajectory_interpolator_tb: self-checking bench for the point table
// Drives insert and query words, predicts each answer from a private copy of
// the sorted table, box and span, and compares every result word by field.
// ---------------------------------------------------------------------------
module sorted_trajectory_interpolator_tb;
    import sti_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 400;

    typedef struct {
        logic        func;
        logic [31:0] t;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          drain;
    } point_word_t;

    typedef struct {
        logic [2:0][31:0] pos;
        logic [1:0]       status;
        logic             span;
        logic [5:0][31:0] box;
    } answer_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [287:0] m_tdata;
    logic [2:0]   m_tuser;

    point_word_t pending_q[$];
    answer_t     answer_q[$];
    point_word_t in_flight;
    int          fail_count = 0;
    int          words_sent = 0;
    int          quiet_cycles = 0;

    // private copy of the table, box and span
    logic [31:0]        tbl_time[TABLE_DEPTH];
    logic signed [31:0] tbl_pos[TABLE_DEPTH][3];
    int                 tbl_count = 0;
    logic signed [31:0] low_c[3] = '{POS_MAX, POS_MAX, POS_MAX};
    logic signed [31:0] high_c[3] = '{POS_MIN, POS_MIN, POS_MIN};
    logic [31:0]        t_first = 32'hFFFF_FFFF;
    logic [31:0]        t_last = 32'h0;

    sorted_trajectory_interpolator #(.DEPTH(TABLE_DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // entries with time below t, or not above t when incl is set
    function automatic int entries_before(logic [31:0] t, bit incl);
        int n;
        n = 0;
        for (int i = 0; i < tbl_count; i++)
            if (incl ? (tbl_time[i] <= t) : (tbl_time[i] < t)) n++;
        return n;
    endfunction

    // linear blend on one axis, quotient truncated toward zero
    function automatic logic [31:0] blend_axis(longint last, longint cur,
                                               bit [63:0] num, bit [63:0] den);
        longint    dir;
        bit [63:0] mag;
        bit [63:0] q;
        longint    res;
        dir = cur - last;
        mag = (dir < 0) ? -dir : dir;
        q = (mag * num) / den;
        res = (dir < 0) ? last - longint'(q) : last + longint'(q);
        return res[31:0];
    endfunction

    // update the table copy for one accepted word and queue its answer
    task automatic predict_answer(input point_word_t w);
        answer_t a;
        int      pos;
        int      k;
        logic signed [31:0] v[3];
        bit [63:0] num;
        bit [63:0] den;
        a.pos = '0;
        a.status = STAT_OK;
        v[0] = w.x;
        v[1] = w.y;
        v[2] = w.z;
        if (w.func == FUNC_INSERT) begin
            if (tbl_count >= TABLE_DEPTH) begin
                a.status = STAT_FULL;
            end else begin
                pos = entries_before(w.t, 1'b1);
                for (int i = tbl_count; i > pos; i--) begin
                    tbl_time[i] = tbl_time[i-1];
                    tbl_pos[i] = tbl_pos[i-1];
                end
                tbl_time[pos] = w.t;
                tbl_pos[pos] = v;
                tbl_count++;
                for (int i = 0; i < 3; i++) begin
                    if (v[i] < low_c[i]) low_c[i] = v[i];
                    if (v[i] > high_c[i]) high_c[i] = v[i];
                end
                if (w.t < t_first) t_first = w.t;
                if (w.t > t_last) t_last = w.t;
            end
        end else begin
            k = entries_before(w.t, 1'b0);
            if (k >= tbl_count) begin
                a.status = STAT_PAST;
            end else if (k == 0) begin
                for (int i = 0; i < 3; i++) a.pos[i] = tbl_pos[0][i];
                a.status = STAT_CLAMP;
            end else begin
                num = w.t - tbl_time[k-1];
                den = tbl_time[k] - tbl_time[k-1];
                for (int i = 0; i < 3; i++)
                    a.pos[i] = blend_axis(tbl_pos[k-1][i], tbl_pos[k][i], num, den);
            end
        end
        a.span = (tbl_count != 0) && (w.t >= t_first) && (w.t <= t_last);
        for (int i = 0; i < 3; i++) begin
            a.box[i] = low_c[i];
            a.box[i+3] = high_c[i];
        end
        answer_q.push_back(a);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %h actual %h", name, want, got);
            fail_count++;
        end
    endtask

    function automatic logic [31:0] rand_time();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(4000);
        if (r < 90) return $urandom;
        return r[0] ? 32'hFFFF_FFFF : 32'h0;
    endfunction

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 90) return $urandom;
        if (r < 95) return POS_MAX;
        return POS_MIN;
    endfunction

    task automatic add_word(input logic f, input logic [31:0] t, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z, input bit drain);
        point_word_t w;
        w.func = f;
        w.t = t;
        w.x = x;
        w.y = y;
        w.z = z;
        w.drain = drain;
        pending_q.push_back(w);
    endtask

    // driver: hold a word until taken, then predict and load the next one
    always @(posedge aclk) begin
        bit          taken;
        bit          send;
        point_word_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            taken = s_tvalid && s_tready;
            if (taken) predict_answer(in_flight);
            send = 1'b0;
            if ((!s_tvalid || taken) && pending_q.size() > 0) begin
                nxt = pending_q[0];
                send = !(nxt.drain && (answer_q.size() > 0 || taken));
                if ((words_sent < 300 || words_sent >= 450) && $urandom_range(99) < 22)
                    send = 1'b0;
            end
            if (send) begin
                void'(pending_q.pop_front());
                in_flight <= nxt;
                s_tdata <= {nxt.z, nxt.y, nxt.x, nxt.t};
                s_tuser <= nxt.func;
                words_sent <= words_sent + 1;
                s_tvalid <= 1'b1;
            end else if (taken) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each result word with the oldest answer
    always @(posedge aclk) begin
        answer_t a;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    $error("result word with no answer pending");
                    fail_count++;
                end else begin
                    a = answer_q.pop_front();
                    check_field("out_x", a.pos[0], m_tdata[31:0]);
                    check_field("out_y", a.pos[1], m_tdata[63:32]);
                    check_field("out_z", a.pos[2], m_tdata[95:64]);
                    check_field("box_min_x", a.box[0], m_tdata[127:96]);
                    check_field("box_min_y", a.box[1], m_tdata[159:128]);
                    check_field("box_min_z", a.box[2], m_tdata[191:160]);
                    check_field("box_max_x", a.box[3], m_tdata[223:192]);
                    check_field("box_max_y", a.box[4], m_tdata[255:224]);
                    check_field("box_max_z", a.box[5], m_tdata[287:256]);
                    check_field("status", a.status, m_tuser[1:0]);
                    check_field("in_span", a.span, m_tuser[2]);
                end
            end
            m_tready <= (words_sent >= 300 && words_sent < 450) || ($urandom_range(99) >= 22);
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // directed: empty table, extremes, equal times, clamp, past end, blend
        add_word(FUNC_QUERY, 32'd50, 0, 0, 0, 0);
        add_word(FUNC_INSERT, 32'd100, POS_MAX, POS_MIN, 32'd7, 0);
        add_word(FUNC_QUERY, 32'd0, 0, 0, 0, 0);
        add_word(FUNC_QUERY, 32'd100, 0, 0, 0, 0);
        add_word(FUNC_INSERT, 32'd100, 32'd5, 32'd5, 32'd5, 0);
        add_word(FUNC_QUERY, 32'd100, 0, 0, 0, 0);
        add_word(FUNC_INSERT, 32'd300, POS_MIN, POS_MAX, -32'sd9, 0);
        add_word(FUNC_QUERY, 32'd200, 0, 0, 0, 0);
        add_word(FUNC_QUERY, 32'd299, 0, 0, 0, 0);
        add_word(FUNC_QUERY, 32'd301, 0, 0, 0, 0);
        add_word(FUNC_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h0, POS_MAX, 0);
        add_word(FUNC_INSERT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, POS_MIN, 0);
        add_word(FUNC_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_word(FUNC_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_word(FUNC_QUERY, 32'd0, 0, 0, 0, 0);
        add_word(FUNC_QUERY, 32'd150, 0, 0, 0, 1);
        // random: mixed, the table fills and later inserts are refused
        for (int i = 0; i < 800; i++) begin
            if ($urandom_range(99) < 50)
                add_word(FUNC_INSERT, rand_time(), rand_coord(), rand_coord(), rand_coord(),
                         i == 400);
            else
                add_word(FUNC_QUERY, rand_time(), $urandom, $urandom, $urandom, i == 400);
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_q.size() == 0 && !s_tvalid && answer_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && answer_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
